FILE: rtl/core/obd_pid_value_decoder_assert.svh
// assertion macros used by the port checker of the pid value decoder
// needs signals named clock and reset in the scope of each use
`ifndef OBD_PID_VALUE_DECODER_ASSERT_SVH
`define OBD_PID_VALUE_DECODER_ASSERT_SVH

// same-cycle implication
`define OPVD_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define OPVD_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/opvd_pkg.sv
// shared types and constants of the pid value decoder
// no dependencies
package opvd_pkg;

   localparam int PID_ENTRIES = 256;
   localparam int IDX_W       = (PID_ENTRIES > 1) ? $clog2(PID_ENTRIES) : 1;

   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_ADDR_W-1:0] REG_REPLY_ID_ADDR = '0;

   localparam logic [10:0] RESET_REPLY_ID = 11'h7E8;
   localparam logic [31:0] RESET_VALUE    = 32'hFFFF_FF38;

   // conversion codes, 14 and 15 fall to the raw byte
   localparam logic [3:0] CONV_SBYTE      = 4'd0;
   localparam logic [3:0] CONV_TEMP       = 4'd1;
   localparam logic [3:0] CONV_TRIM       = 4'd2;
   localparam logic [3:0] CONV_BYTE_X10   = 4'd3;
   localparam logic [3:0] CONV_BYTE_X3    = 4'd4;
   localparam logic [3:0] CONV_PERCENT    = 4'd5;
   localparam logic [3:0] CONV_BYTE       = 4'd6;
   localparam logic [3:0] CONV_WORD       = 4'd7;
   localparam logic [3:0] CONV_WORD_X10   = 4'd8;
   localparam logic [3:0] CONV_WORD_DIV4  = 4'd9;
   localparam logic [3:0] CONV_WORD_RAW0  = 4'd10;
   localparam logic [3:0] CONV_WORD_RAW1  = 4'd11;
   localparam logic [3:0] CONV_WORD_RAW2  = 4'd12;
   localparam logic [3:0] CONV_LONG       = 4'd13;

   typedef struct packed {
      logic [10:0] can_id;
      logic [7:0]  pid;
      logic [3:0]  conversion;
      logic [7:0]  data_first;
      logic [7:0]  data_second;
      logic [7:0]  data_third;
      logic [7:0]  data_fourth;
   } opvd_req_type;

   typedef struct packed {
      logic [7:0]         pid_out;
      logic signed [31:0] value;
      logic               changed;
   } opvd_rsp_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic [31:0]      data;
   } opvd_wr_type;

   function automatic logic [IDX_W-1:0] pid_index(input logic [7:0] pid);
      return IDX_W'(pid % PID_ENTRIES);
   endfunction

endpackage

FILE: rtl/core/opvd_decode.sv
// conversion of one reply frame's payload bytes to an engineering value
// depends on opvd_pkg
module opvd_decode
   import opvd_pkg::*;
(
   input  opvd_req_type frame,
   output logic [31:0]  value_out
);

   logic [7:0]         b0;
   logic [15:0]        word;
   logic signed [15:0] s16;
   logic signed [15:0] prod16;
   logic signed [15:0] quo16;
   logic               round_up;
   logic [15:0]        pct_num;
   logic [7:0]         pct_est;
   logic [15:0]        pct_rem;
   logic [7:0]         pct_quo;

   assign b0   = frame.data_first;
   assign word = {frame.data_first, frame.data_second};

   // signed byte * 100 / 128, truncated toward zero
   assign s16      = {{8{b0[7]}}, b0};
   assign prod16   = (s16 <<< 6) + (s16 <<< 5) + (s16 <<< 2);
   assign round_up = prod16[15] && (prod16[6:0] != 7'd0);
   assign quo16    = (prod16 >>> 7) + $signed({15'd0, round_up});

   // byte * 100 / 255: n/256 is at most one below the quotient
   assign pct_num = {b0, 6'd0} + {1'b0, b0, 5'd0} + {6'd0, b0, 2'd0};
   assign pct_est = pct_num[15:8];
   assign pct_rem = pct_num - {pct_est, 8'd0} + {8'd0, pct_est};
   assign pct_quo = pct_est + {7'd0, (pct_rem >= 16'd255)};

   always_comb begin
      unique case (frame.conversion) inside
         CONV_SBYTE:     value_out = {{24{b0[7]}}, b0};
         CONV_TEMP:      value_out = {24'd0, b0} - 32'd40;
         CONV_TRIM:      value_out = {{16{quo16[15]}}, quo16} - 32'd100;
         CONV_BYTE_X10:  value_out = {21'd0, b0, 3'd0} + {23'd0, b0, 1'b0};
         CONV_BYTE_X3:   value_out = {23'd0, b0, 1'b0} + {24'd0, b0};
         CONV_PERCENT:   value_out = {24'd0, pct_quo};
         CONV_WORD, CONV_WORD_RAW0, CONV_WORD_RAW1, CONV_WORD_RAW2:
                         value_out = {16'd0, word};
         CONV_WORD_X10:  value_out = {13'd0, word, 3'd0} + {15'd0, word, 1'b0};
         CONV_WORD_DIV4: value_out = {18'd0, word[15:2]};
         CONV_LONG:      value_out = {frame.data_first, frame.data_second,
                                      frame.data_third, frame.data_fourth};
         default:        value_out = {24'd0, b0};
      endcase
   end

endmodule

FILE: rtl/core/opvd_pid_store.sv
// per-pid store of the last decoded value, with valid bits and write forwarding
// depends on opvd_pkg
module opvd_pid_store
   import opvd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_idx,
   input  opvd_wr_type      wr,
   output logic [31:0]      prev_value
);

   logic [31:0]            value_mem [PID_ENTRIES];
   logic [PID_ENTRIES-1:0] valid_ff;
   logic [PID_ENTRIES-1:0] valid_in;
   logic [31:0]            rd_data_ff;
   logic                   rd_valid_ff;
   logic [IDX_W-1:0]       rd_idx_ff;
   logic                   fwd_valid_ff;
   logic [IDX_W-1:0]       fwd_idx_ff;
   logic [31:0]            fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         value_mem[wr.idx] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= value_mem[rd_idx];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (wr.en) begin
            fwd_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_idx_ff   <= rd_idx;
         rd_valid_ff <= valid_ff[rd_idx];
      end
      if (wr.en) begin
         fwd_idx_ff  <= wr.idx;
         fwd_data_ff <= wr.data;
      end
   end

   // the latest write may land on the same edge as the read, so it wins
   always_comb begin
      if (fwd_valid_ff && (fwd_idx_ff == rd_idx_ff)) begin
         prev_value = fwd_data_ff;
      end else if (rd_valid_ff) begin
         prev_value = rd_data_ff;
      end else begin
         prev_value = RESET_VALUE;
      end
   end

endmodule

FILE: rtl/core/obd_pid_value_decoder.sv
// OBD-II mode 1 reply decoder: usage notes
//
// req_* carries one reply frame per transfer (can id, pid, conversion code,
// four payload bytes). Frames whose can id differs from the reply_id register
// are dropped and leave no trace. rsp_* carries one result per kept frame:
// pid, decoded 32-bit value, and a flag set when the value differs from the
// last one stored for that pid.
// A kept frame passes the input register, where the per-pid memory is read,
// then decode and compare into the result register, which drives rsp_valid.
// One frame per cycle is sustained while rsp_stall is low; the per-pid
// read-modify-write is kept exact by forwarding the last write.
// When the receiver holds rsp_stall, the result stays put, the input register
// fills, and req_stall rises only while both are occupied.
// Reset clears all valid flags, sets reply_id to 0x7E8 and makes every pid
// entry read as -200; no clearing pass, frames are taken right away.
// reply_id is written over the csr_ port at address 0; the user must write it
// only while the block is idle, and the block itself does not enforce this.
// depends on opvd_pkg, opvd_decode, opvd_pid_store
module obd_pid_value_decoder
   import opvd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  opvd_req_type          req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output opvd_rsp_type          rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [10:0]  reply_id_ff;
   logic         req_accept;
   logic         req_hit;
   logic         advance;
   logic         s1_valid_ff;
   logic         s1_valid_in;
   opvd_req_type s1_ff;
   logic [31:0]  s1_value;
   logic [31:0]  prev_value;
   opvd_wr_type  store_wr;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   opvd_rsp_type rsp_ff;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_REPLY_ID_ADDR) ?
                       {{(CSR_DATA_W-11){1'b0}}, reply_id_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         reply_id_ff <= RESET_REPLY_ID;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr == REG_REPLY_ID_ADDR)) begin
         reply_id_ff <= csr_pwdata[10:0];
      end
   end

   // flow control
   assign advance      = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = s1_valid_ff && !advance;
   assign req_accept   = req_valid && !req_stall;
   assign req_hit      = (req_payload.can_id == reply_id_ff);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_comb begin
      if (req_accept) begin
         s1_valid_in = req_hit;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff <= req_payload;
      end
   end

   opvd_decode u_decode (
      .frame     (s1_ff),
      .value_out (s1_value)
   );

   assign store_wr.en   = advance;
   assign store_wr.idx  = pid_index(s1_ff.pid);
   assign store_wr.data = s1_value;

   opvd_pid_store u_store (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (req_accept && req_hit),
      .rd_idx     (pid_index(req_payload.pid)),
      .wr         (store_wr),
      .prev_value (prev_value)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff.pid_out <= s1_ff.pid;
         rsp_ff.value   <= s1_value;
         rsp_ff.changed <= (s1_value != prev_value);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: rtl/core/opvd_port_checker.sv
// port-level checks of the pid value decoder, bound to the top level
// depends on opvd_pkg and obd_pid_value_decoder_assert.svh
`include "obd_pid_value_decoder_assert.svh"

module opvd_port_checker
   import opvd_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input opvd_req_type req_payload,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input opvd_rsp_type rsp_payload
);

   logic req_seen;

   assign req_seen = req_valid && (req_payload.pid == req_payload.pid);

   `OPVD_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "stalled result changed")

   `OPVD_ASSERT_IMP(a_reset_empty, $past(reset), !rsp_valid && !req_stall, "pipeline not empty after reset")

   `OPVD_ASSERT_IMP(a_stall_cause, req_stall || (req_seen && req_stall), rsp_valid && rsp_stall, "input stalled while result path free")

   `OPVD_ASSERT_IMP(a_same_value, (rsp_valid && !rsp_stall) ##1 (rsp_valid && (rsp_payload.pid_out == $past(rsp_payload.pid_out)) && (rsp_payload.value == $past(rsp_payload.value))), !rsp_payload.changed, "repeated value flagged as changed")

endmodule

bind obd_pid_value_decoder opvd_port_checker u_port_checker (.*);

FILE: tb/sv/obd_pid_value_decoder_checker.sv
// checker of the pid value decoder: watches the req, rsp and csr ports,
// predicts every decoded reading and compares it with the result transfers
// depends on opvd_pkg
`timescale 1ns / 1ps

module obd_pid_value_decoder_checker
   import opvd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  opvd_req_type          req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  opvd_rsp_type          rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   input  logic                  csr_pready,
   output int                    fail_count,
   output int                    pending_count
);

   logic [10:0]  reply_id_copy = RESET_REPLY_ID;
   logic [31:0]  last_reading [PID_ENTRIES];
   opvd_rsp_type expected_readings [$];
   int           failures = 0;

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

   // engineering value of one frame under its conversion code
   function automatic logic [31:0] scale_reading(input logic [3:0] conv,
                                                 input logic [7:0] b0,
                                                 input logic [7:0] b1,
                                                 input logic [7:0] b2,
                                                 input logic [7:0] b3);
      int sbyte;
      int ubyte;
      int word;
      int r;
      sbyte = $signed(b0);
      ubyte = b0;
      word  = {16'd0, b0, b1};
      case (conv)
         CONV_SBYTE:     r = sbyte;
         CONV_TEMP:      r = ubyte - 40;
         CONV_TRIM:      r = (sbyte * 100) / 128 - 100;
         CONV_BYTE_X10:  r = ubyte * 10;
         CONV_BYTE_X3:   r = ubyte * 3;
         CONV_PERCENT:   r = (ubyte * 100) / 255;
         CONV_WORD, CONV_WORD_RAW0, CONV_WORD_RAW1, CONV_WORD_RAW2: r = word;
         CONV_WORD_X10:  r = word * 10;
         CONV_WORD_DIV4: r = word / 4;
         CONV_LONG:      r = {b0, b1, b2, b3};
         default:        r = ubyte;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : watch
      opvd_rsp_type want;
      int           entry;
      logic [31:0]  reading;
      if (reset) begin
         reply_id_copy = RESET_REPLY_ID;
         for (int i = 0; i < PID_ENTRIES; i++) last_reading[i] = RESET_VALUE;
         expected_readings.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               $error("result transfer with no frame pending: pid_out %0d value %0d",
                      rsp_payload.pid_out, rsp_payload.value);
               failures++;
            end else begin
               want = expected_readings.pop_front();
               if (rsp_payload.pid_out !== want.pid_out) begin
                  $error("pid_out expected %0d actual %0d", want.pid_out,
                         rsp_payload.pid_out);
                  failures++;
               end
               if (rsp_payload.value !== want.value) begin
                  $error("value expected %0d actual %0d", want.value, rsp_payload.value);
                  failures++;
               end
               if (rsp_payload.changed !== want.changed) begin
                  $error("changed expected %0d actual %0d", want.changed,
                         rsp_payload.changed);
                  failures++;
               end
            end
         end
         // frames from other ids leave no result and no trace in the table
         if (req_valid && !req_stall && req_payload.can_id == reply_id_copy) begin
            entry   = req_payload.pid % PID_ENTRIES;
            reading = scale_reading(req_payload.conversion, req_payload.data_first,
                                    req_payload.data_second, req_payload.data_third,
                                    req_payload.data_fourth);
            want.pid_out = req_payload.pid;
            want.value   = reading;
            want.changed = (reading != last_reading[entry]);
            last_reading[entry] = reading;
            expected_readings.push_back(want);
         end
         if (csr_psel && csr_penable && csr_pready && csr_paddr == REG_REPLY_ID_ADDR) begin
            if (csr_pwrite) begin
               reply_id_copy = csr_pwdata[10:0];
            end else if (csr_prdata[10:0] !== reply_id_copy) begin
               $error("reply_id expected %0d actual %0d", reply_id_copy, csr_prdata[10:0]);
               failures++;
            end
         end
      end
      fail_count    <= failures;
      pending_count <= expected_readings.size();
   end

endmodule

FILE: tb/sv/tb_obd_pid_value_decoder.sv
// top of the pid value decoder testbench: clock, reset, frame and csr stimulus,
// receiver stalls and the verdict
// depends on opvd_pkg, obd_pid_value_decoder and obd_pid_value_decoder_checker
`timescale 1ns / 1ps

module tb_obd_pid_value_decoder;
   import opvd_pkg::*;

   localparam int         CYCLE_LIMIT     = 400000;
   localparam int         SETTLE_CYCLES   = 8;
   localparam int         FRAMES_PER_SET  = 290;
   localparam logic [3:0] CONV_UNKNOWN_LO = 4'd14;
   localparam logic [3:0] CONV_UNKNOWN_HI = 4'd15;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   opvd_req_type          req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   opvd_rsp_type          rsp_payload;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int          fail_count;
   int          pending_count;
   int          cycle_count   = 0;
   logic [10:0] cur_reply_id  = RESET_REPLY_ID;
   int          stall_mode    = 0;
   int          stall_left    = 0;
   logic [7:0]  stall_tick    = '0;

   obd_pid_value_decoder uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   obd_pid_value_decoder_checker decode_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver stall pattern: free, light, heavy and periodic stretches
   always @(posedge clock) begin
      stall_tick <= stall_tick + 8'd1;
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         2:       rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= stall_tick[2];
      endcase
   end

   function automatic logic [7:0] corner_byte();
      case ($urandom_range(0, 3))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h80;
         default: return 8'h7F;
      endcase
   endfunction

   task automatic put_frame(input opvd_req_type f);
      req_valid   <= 1'b1;
      req_payload <= f;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // n must be at least one so valid never drops and rises in one step
   task automatic idle_sender(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic directed_frame(input logic [10:0] can_id, input logic [7:0] pid,
                                 input logic [3:0] conv, input logic [7:0] b0,
                                 input logic [7:0] b1, input logic [7:0] b2,
                                 input logic [7:0] b3);
      opvd_req_type f;
      f.can_id      = can_id;
      f.pid         = pid;
      f.conversion  = conv;
      f.data_first  = b0;
      f.data_second = b1;
      f.data_third  = b2;
      f.data_fourth = b3;
      put_frame(f);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_transfer(input logic wr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= REG_REPLY_ID_ADDR;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_reply_id(input logic [10:0] id);
      csr_transfer(1'b1, {21'($urandom), id});
      cur_reply_id = id;
      csr_transfer(1'b0, '0);
   endtask

   task automatic random_frames(input int n);
      opvd_req_type f;
      opvd_req_type prev;
      int           sent;
      int           burst;
      int           sel;
      sent = 0;
      prev = '0;
      prev.can_id = cur_reply_id;
      while (sent < n) begin
         burst = $urandom_range(1, 24);
         while (burst > 0 && sent < n) begin
            sel = $urandom_range(0, 99);
            if (sel < 15) begin
               // same frame again, reading unchanged
               f = prev;
            end else begin
               if (sel < 85)
                  f.can_id = cur_reply_id;
               else if (sel < 93)
                  f.can_id = cur_reply_id ^ (11'd1 << $urandom_range(0, 10));
               else
                  f.can_id = 11'($urandom);
               f.pid         = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                                           : 8'($urandom);
               f.conversion  = 4'($urandom);
               f.data_first  = ($urandom_range(0, 4) == 0) ? corner_byte() : 8'($urandom);
               f.data_second = ($urandom_range(0, 4) == 0) ? corner_byte() : 8'($urandom);
               f.data_third  = ($urandom_range(0, 4) == 0) ? corner_byte() : 8'($urandom);
               f.data_fourth = ($urandom_range(0, 4) == 0) ? corner_byte() : 8'($urandom);
            end
            put_frame(f);
            prev = f;
            sent++;
            burst--;
         end
         idle_sender(($urandom_range(0, 3) == 0) ? $urandom_range(8, 30)
                                                 : $urandom_range(1, 4));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_transfer(1'b0, '0);

      directed_frame(RESET_REPLY_ID, 8'd0,   CONV_SBYTE,      8'h80, 8'h00, 8'h00, 8'h00);
      directed_frame(RESET_REPLY_ID, 8'd0,   CONV_SBYTE,      8'h7F, 8'h00, 8'h00, 8'h00);
      directed_frame(RESET_REPLY_ID, 8'd1,   CONV_TEMP,       8'h00, 8'h00, 8'h00, 8'h00);
      directed_frame(RESET_REPLY_ID, 8'd1,   CONV_TEMP,       8'hFF, 8'hFF, 8'hFF, 8'hFF);
      // decodes to minus 200 on a fresh pid, so no change is flagged
      directed_frame(RESET_REPLY_ID, 8'd2,   CONV_TRIM,       8'h80, 8'h00, 8'h00, 8'h00);
      directed_frame(RESET_REPLY_ID, 8'd2,   CONV_TRIM,       8'hFF, 8'h00, 8'h00, 8'h00);
      directed_frame(RESET_REPLY_ID, 8'd2,   CONV_TRIM,       8'h7F, 8'h00, 8'h00, 8'h00);
      directed_frame(RESET_REPLY_ID, 8'd3,   CONV_BYTE_X10,   8'hFF, 8'h00, 8'h00, 8'h00);
      directed_frame(RESET_REPLY_ID, 8'd4,   CONV_BYTE_X3,    8'hFF, 8'h00, 8'h00, 8'h00);
      directed_frame(RESET_REPLY_ID, 8'd5,   CONV_PERCENT,    8'hFF, 8'h00, 8'h00, 8'h00);
      directed_frame(RESET_REPLY_ID, 8'd5,   CONV_PERCENT,    8'h01, 8'h00, 8'h00, 8'h00);
      directed_frame(RESET_REPLY_ID, 8'd6,   CONV_BYTE,       8'hAB, 8'hFF, 8'hFF, 8'hFF);
      directed_frame(RESET_REPLY_ID, 8'd7,   CONV_WORD,       8'hFF, 8'hFF, 8'h00, 8'h00);
      directed_frame(RESET_REPLY_ID, 8'd8,   CONV_WORD_X10,   8'hFF, 8'hFF, 8'h00, 8'h00);
      directed_frame(RESET_REPLY_ID, 8'd9,   CONV_WORD_DIV4,  8'hFF, 8'hFF, 8'hFF, 8'hFF);
      directed_frame(RESET_REPLY_ID, 8'd10,  CONV_WORD_RAW0,  8'h12, 8'h34, 8'h00, 8'h00);
      directed_frame(RESET_REPLY_ID, 8'd11,  CONV_WORD_RAW1,  8'h00, 8'h00, 8'hFF, 8'hFF);
      directed_frame(RESET_REPLY_ID, 8'd12,  CONV_WORD_RAW2,  8'h80, 8'h01, 8'h00, 8'h00);
      directed_frame(RESET_REPLY_ID, 8'd13,  CONV_LONG,       8'h80, 8'h00, 8'h00, 8'h00);
      directed_frame(RESET_REPLY_ID, 8'd254, CONV_LONG,       8'hFF, 8'hFF, 8'hFF, 8'h38);
      directed_frame(RESET_REPLY_ID, 8'd255, CONV_UNKNOWN_LO, 8'h5A, 8'hFF, 8'hFF, 8'hFF);
      directed_frame(RESET_REPLY_ID, 8'd255, CONV_UNKNOWN_HI, 8'h5A, 8'h00, 8'h00, 8'h00);
      // foreign ids, dropped without touching the table
      directed_frame(11'h7E9,        8'd255, CONV_LONG,       8'h01, 8'h02, 8'h03, 8'h04);
      directed_frame(11'h000,        8'd0,   CONV_SBYTE,      8'h00, 8'h00, 8'h00, 8'h00);
      directed_frame(RESET_REPLY_ID, 8'd0,   CONV_SBYTE,      8'h7F, 8'h00, 8'h00, 8'h00);
      drain_results();

      set_reply_id(11'h000);
      random_frames(FRAMES_PER_SET);
      drain_results();
      set_reply_id(11'h7FF);
      random_frames(FRAMES_PER_SET);
      drain_results();
      set_reply_id(11'($urandom));
      random_frames(FRAMES_PER_SET);
      drain_results();
      set_reply_id(RESET_REPLY_ID);
      random_frames(FRAMES_PER_SET);
      drain_results();

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
